// ===== src/ipsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsf_pkg
// Shared types, frame constants and the glyph lookup for the isolated pixel
// smoothing filter.
// ----------------------------------------------------------------------------
package ipsf_pkg;

   // frame geometry
   localparam int FRAME_WIDTH  = 30;
   localparam int FRAME_HEIGHT = 20;
   localparam int COL_WIDTH    = $clog2(FRAME_WIDTH);
   localparam int ROW_WIDTH    = $clog2(FRAME_HEIGHT);

   // one pixel delay per cell: two full rows of history
   localparam int CHAIN_LEN    = 2 * FRAME_WIDTH;

   // tap offsets into the chain (index 0 holds the pixel one step back)
   localparam int TAP_RIGHT    = FRAME_WIDTH - 2;
   localparam int TAP_CENTER   = FRAME_WIDTH - 1;
   localparam int TAP_LEFT     = FRAME_WIDTH;
   localparam int TAP_UP       = CHAIN_LEN - 1;

   // field widths
   localparam int LEVEL_WIDTH   = 4;
   localparam int OUT_POS_WIDTH = 5;
   localparam int GLYPH_WIDTH   = 7;
   localparam int SUM_WIDTH     = 6;
   localparam int COUNT_WIDTH   = 3;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX       = 4'd9;
   localparam logic [LEVEL_WIDTH-1:0] THRESHOLD_RESET = 4'd1;

   // divide by three: floor(s * 43 / 128) is exact for s below 128
   localparam int DIV3_MUL   = 43;
   localparam int DIV3_SHIFT = 7;

   typedef logic [LEVEL_WIDTH-1:0] level_type;

   // 3x3 cross window handed from the cell chain to the filter
   typedef struct packed {
      level_type up;
      level_type left;
      level_type center;
      level_type right;
      level_type down;
      logic      has_up;
      logic      has_left;
      logic      has_right;
      logic      has_down;
   } window_type;

   // display character for a level
   function automatic logic [GLYPH_WIDTH-1:0] level_glyph(input level_type lv);
      logic [GLYPH_WIDTH-1:0] g;
      case (lv)
         4'd0:    g = 7'h20;   // space
         4'd1:    g = 7'h2E;   // .
         4'd2:    g = 7'h27;   // '
         4'd3:    g = 7'h3A;   // :
         4'd4:    g = 7'h7E;   // ~
         4'd5:    g = 7'h2A;   // *
         4'd6:    g = 7'h3D;   // =
         4'd7:    g = 7'h24;   // $
         4'd8:    g = 7'h25;   // %
         default: g = 7'h23;   // #
      endcase
      return g;
   endfunction

endpackage

// ===== src/ipsf_cell.sv =====
// ----------------------------------------------------------------------------
// ipsf_cell
// One pixel stage of the line delay chain; takes its neighbor's level on
// every shift.
// ----------------------------------------------------------------------------
module ipsf_cell
   import ipsf_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  level_type level_d,
   output level_type level_q
);

   level_type level_ff;
   level_type level_in;

   // hold unless the chain advances
   assign level_in = shift ? level_d : level_ff;

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level_q = level_ff;

endmodule

// ===== src/ipsf_window.sv =====
// ----------------------------------------------------------------------------
// ipsf_window
// Despeckle decision for one cross window: a pixel that differs from every
// existing neighbor by more than the threshold takes their truncated mean.
// ----------------------------------------------------------------------------
module ipsf_window
   import ipsf_pkg::*;
(
   input  window_type win,
   input  level_type  threshold,
   output level_type  filtered
);

   level_type                nb     [4];
   logic                     has    [4];
   logic [SUM_WIDTH-1:0]     sum;
   logic [COUNT_WIDTH-1:0]   count;
   logic                     keep;
   logic [LEVEL_WIDTH-1:0]   diff;
   logic [SUM_WIDTH+6-1:0]   prod3;
   logic [SUM_WIDTH-1:0]     avg;
   level_type                result;

   assign nb[0]  = win.up;
   assign nb[1]  = win.left;
   assign nb[2]  = win.down;
   assign nb[3]  = win.right;
   assign has[0] = win.has_up;
   assign has[1] = win.has_left;
   assign has[2] = win.has_down;
   assign has[3] = win.has_right;

   // compare each neighbor, accumulate the distant ones
   always_comb begin
      sum   = '0;
      count = '0;
      keep  = 1'b0;
      diff  = '0;
      for (int k = 0; k < 4; k++) begin
         diff = (nb[k] > win.center) ? (nb[k] - win.center) : (win.center - nb[k]);
         if (has[k]) begin
            if (diff > threshold) begin
               sum   = sum + SUM_WIDTH'(nb[k]);
               count = count + COUNT_WIDTH'(1);
            end else begin
               keep = 1'b1;
            end
         end
      end
   end

   // truncated mean by count
   assign prod3 = (SUM_WIDTH+6)'(sum) * (SUM_WIDTH+6)'(DIV3_MUL);

   always_comb begin
      case (count)
         3'd1:    avg = sum;
         3'd2:    avg = sum >> 1;
         3'd3:    avg = SUM_WIDTH'(prod3 >> DIV3_SHIFT);
         default: avg = sum >> 2;
      endcase
   end

   always_comb begin
      if (!keep && (count != '0)) begin
         result = (avg > SUM_WIDTH'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_WIDTH'(avg);
      end else begin
         result = win.center;
      end
   end

   assign filtered = result;

endmodule

// ===== src/isolated_pixel_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_smoothing_filter
// Four-neighbor despeckle filter over a raster stream of 0..9 levels, built
// as a chain of pixel cells holding two rows of history.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    level
//   rsp      out        valid / stall    row, column, filtered_level, glyph,
//                                        frame_done
//   csr      in         valid / ready    difference_threshold
//
// One pixel is taken per cycle unless req stalls; its result (from row one
// up) is registered and shows on rsp in the next cycle. After the last pixel
// of the frame the last row (FRAME_WIDTH items) drains from the chain with
// req stalled, one item per cycle unless rsp stalls. req stalls whenever
// a result waits under rsp stall. Synchronous reset clears position
// counters, drain state and the output valid; the threshold returns to 1.
// ----------------------------------------------------------------------------
module isolated_pixel_smoothing_filter
   import ipsf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // pixel input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [LEVEL_WIDTH-1:0]   req_level,
   // filtered result
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_POS_WIDTH-1:0] rsp_row,
   output logic [OUT_POS_WIDTH-1:0] rsp_column,
   output logic [LEVEL_WIDTH-1:0]   rsp_filtered_level,
   output logic [GLYPH_WIDTH-1:0]   rsp_glyph,
   output logic                     rsp_frame_done,
   // threshold register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEVEL_WIDTH-1:0]   csr_difference_threshold
);

   localparam logic [COL_WIDTH-1:0] COL_LAST = COL_WIDTH'(FRAME_WIDTH - 1);
   localparam logic [ROW_WIDTH-1:0] ROW_LAST = ROW_WIDTH'(FRAME_HEIGHT - 1);

   level_type                  threshold_ff, threshold_in;
   logic [ROW_WIDTH-1:0]       in_row_ff, in_row_in;
   logic [COL_WIDTH-1:0]       in_col_ff, in_col_in;
   logic                       drain_ff, drain_in;
   logic [COL_WIDTH-1:0]       drain_col_ff, drain_col_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_POS_WIDTH-1:0]   rsp_row_ff, rsp_row_in;
   logic [OUT_POS_WIDTH-1:0]   rsp_col_ff, rsp_col_in;
   level_type                  rsp_level_ff, rsp_level_in;
   logic [GLYPH_WIDTH-1:0]     rsp_glyph_ff, rsp_glyph_in;
   logic                       rsp_done_ff, rsp_done_in;

   logic                       out_free;
   logic                       accept;
   logic                       step;
   level_type                  level_sat;
   level_type                  chain_in;
   level_type                  tap [CHAIN_LEN];
   logic [COL_WIDTH-1:0]       col;
   window_type                 win;
   level_type                  filtered;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = drain_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign step      = accept || (drain_ff && out_free);
   assign csr_ready = 1'b1;

   // input saturation; the drain shifts in a don't-care level
   assign level_sat = (req_level > LEVEL_MAX) ? LEVEL_MAX : req_level;
   assign chain_in  = drain_ff ? '0 : level_sat;

   // delay chain: cell k holds the pixel k+1 steps back
   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
      level_type cell_d;
      if (k == 0) begin : g_head
         assign cell_d = chain_in;
      end else begin : g_body
         assign cell_d = tap[k-1];
      end
      ipsf_cell u_cell (
         .clock   (clock),
         .shift   (step),
         .level_d (cell_d),
         .level_q (tap[k])
      );
   end

   // cross window around the pixel one row behind the incoming one
   assign col = drain_ff ? drain_col_ff : in_col_ff;

   always_comb begin
      win.up        = tap[TAP_UP];
      win.left      = tap[TAP_LEFT];
      win.center    = tap[TAP_CENTER];
      win.right     = tap[TAP_RIGHT];
      win.down      = level_sat;
      win.has_up    = drain_ff || (in_row_ff > ROW_WIDTH'(1));
      win.has_left  = (col != '0);
      win.has_right = (col != COL_LAST);
      win.has_down  = !drain_ff;
   end

   ipsf_window u_window (
      .win       (win),
      .threshold (threshold_ff),
      .filtered  (filtered)
   );

   // position counters and end-of-frame drain
   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      drain_in     = drain_ff;
      drain_col_in = drain_col_ff;
      if (accept) begin
         if (in_col_ff == COL_LAST) begin
            in_col_in = '0;
            if (in_row_ff == ROW_LAST) begin
               in_row_in    = '0;
               drain_in     = 1'b1;
               drain_col_in = '0;
            end else begin
               in_row_in = in_row_ff + ROW_WIDTH'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_WIDTH'(1);
         end
      end else if (drain_ff && out_free) begin
         if (drain_col_ff == COL_LAST) begin
            drain_in = 1'b0;
         end
         drain_col_in = drain_col_ff + COL_WIDTH'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_level_in = rsp_level_ff;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_done_in  = rsp_done_ff;
      if (step) begin
         rsp_valid_in = drain_ff || (in_row_ff != '0);
         rsp_row_in   = drain_ff ? OUT_POS_WIDTH'(ROW_LAST)
                                 : OUT_POS_WIDTH'(in_row_ff - ROW_WIDTH'(1));
         rsp_col_in   = OUT_POS_WIDTH'(col);
         rsp_level_in = filtered;
         rsp_glyph_in = level_glyph(filtered);
         rsp_done_in  = drain_ff && (drain_col_ff == COL_LAST);
      end
   end

   // threshold register
   assign threshold_in = (csr_valid && csr_ready) ? csr_difference_threshold : threshold_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         drain_ff     <= 1'b0;
         drain_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         drain_ff     <= drain_in;
         drain_col_ff <= drain_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_level_ff <= rsp_level_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row            = rsp_row_ff;
   assign rsp_column         = rsp_col_ff;
   assign rsp_filtered_level = rsp_level_ff;
   assign rsp_glyph          = rsp_glyph_ff;
   assign rsp_frame_done     = rsp_done_ff;

endmodule
